FILE: design/indexed_ordered_list_macros.svh
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ILO_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define ILO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/ilo_pkg.sv
package ilo_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_FEW    = 2'd3
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [4:0]  position;
        logic [63:0] record;
    } cmd_t;

    typedef struct packed {
        logic [63:0] read_record;
        status_t     status;
        logic [4:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

FILE: design/ilo_mem.sv
module ilo_mem #(
    parameter int DEPTH    = 16,
    parameter int RECORD_W = 64,
    localparam int IDX_W   = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  ilo_pkg::mem_ctl_t    ctl,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [IDX_W-1:0]     raddr,
    input  logic [RECORD_W-1:0]  wdata,
    output logic [RECORD_W-1:0]  rdata
);
    import ilo_pkg::*;

    logic [RECORD_W-1:0] mem_reg [DEPTH];
    logic [RECORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ilo_ctrl.sv
module ilo_ctrl #(
    parameter int DEPTH    = 16,
    parameter int RECORD_W = 64,
    localparam int IDX_W   = $clog2(DEPTH),
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ilo_pkg::cmd_t        cmd,
    output logic                 done,
    output ilo_pkg::result_t     result,
    output ilo_pkg::mem_ctl_t    mem_ctl,
    output logic [IDX_W-1:0]     waddr,
    output logic [IDX_W-1:0]     raddr,
    output logic [RECORD_W-1:0]  wdata,
    input  logic [RECORD_W-1:0]  rdata
);
    import ilo_pkg::*;
    `include "indexed_ordered_list_macros.svh"

    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_RDWAIT  = 6'b000010,
        S_HEADCAP = 6'b000100,
        S_SHRD    = 6'b001000,
        S_SHWR    = 6'b010000,
        S_FIN     = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    op_t                 op_reg, op_next;
    logic [RECORD_W-1:0] rec_reg, rec_next;
    logic [RECORD_W-1:0] first_reg, first_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    logic                accept;
    logic                err_flag;
    status_t             err_st;
    logic [EXT_W-1:0]    pos_ext;
    logic [EXT_W-1:0]    cnt_ext;

    assign accept  = start && (state_reg == S_IDLE);
    assign pos_ext = EXT_W'(cmd.position);
    assign cnt_ext = EXT_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        rec_next    = rec_reg;
        first_next  = first_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_ctl     = '0;
        waddr       = cur_reg;
        raddr       = cur_reg;
        wdata       = rdata;
        err_flag    = 1'b0;
        err_st      = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.op;
                    pos_next = IDX_W'(cmd.position);
                    rec_next = RECORD_W'(cmd.record);
                    case (cmd.op)
                        OP_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                            begin
                                err_flag = 1'b1;
                                err_st   = ST_BADPOS;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                err_flag = 1'b1;
                                err_st   = ST_FULL;
                            end
                            else
                            begin
                                cur_next   = IDX_W'(count_reg);
                                state_next = (pos_ext == cnt_ext) ? S_FIN : S_SHRD;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                err_flag = 1'b1;
                                err_st   = ST_BADPOS;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                raddr         = IDX_W'(cmd.position);
                                state_next    = S_RDWAIT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                err_flag = 1'b1;
                                err_st   = ST_BADPOS;
                            end
                            else
                            begin
                                cur_next   = IDX_W'(cmd.position);
                                state_next = ((pos_ext + EXT_W'(1)) < cnt_ext) ? S_SHRD : S_FIN;
                            end
                        end
                        OP_ROTATE:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                err_flag = 1'b1;
                                err_st   = ST_FEW;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                raddr         = '0;
                                state_next    = S_HEADCAP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (err_flag)
                    begin
                        done_next               = 1'b1;
                        result_next.read_record = '0;
                        result_next.status      = err_st;
                        result_next.entry_count = 5'(count_reg);
                    end
                end
            end
            S_RDWAIT:
            begin
                done_next               = 1'b1;
                result_next.read_record = 64'(rdata);
                result_next.status      = ST_OK;
                result_next.entry_count = 5'(count_reg);
                state_next              = S_IDLE;
            end
            S_HEADCAP:
            begin
                first_next = rdata;
                cur_next   = '0;
                state_next = S_SHRD;
            end
            S_SHRD:
            begin
                mem_ctl.rd_en = 1'b1;
                raddr = (op_reg == OP_INSERT) ? (cur_reg - IDX_W'(1)) : (cur_reg + IDX_W'(1));
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                mem_ctl.wr_en = 1'b1;
                waddr         = cur_reg;
                wdata         = rdata;
                if (op_reg == OP_INSERT)
                begin
                    cur_next   = cur_reg - IDX_W'(1);
                    state_next = ((cur_reg - IDX_W'(1)) == pos_reg) ? S_FIN : S_SHRD;
                end
                else
                begin
                    cur_next   = cur_reg + IDX_W'(1);
                    state_next = ((CNT_W'(cur_reg) + CNT_W'(2)) < count_reg) ? S_SHRD : S_FIN;
                end
            end
            S_FIN:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        waddr         = pos_reg;
                        wdata         = rec_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    OP_REMOVE:
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    OP_ROTATE:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        waddr         = IDX_W'(count_reg - CNT_W'(1));
                        wdata         = first_reg;
                    end
                    default:
                    begin
                    end
                endcase
                done_next               = 1'b1;
                result_next.read_record = '0;
                result_next.status      = ST_OK;
                result_next.entry_count = 5'(count_next);
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // working registers, no reset
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        op_reg     <= op_next;
        rec_reg    <= rec_next;
        first_reg  <= first_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ILO_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ILO_ASSERT_IMP(a_done_when_idle, done_reg, state_reg == S_IDLE)
    `ILO_ASSERT_IMP(a_write_only_busy, mem_ctl.wr_en, state_reg != S_IDLE)
    `ILO_ASSERT_NEXT(a_error_keeps_count, accept && err_flag, done_reg && $stable(count_reg))
    `ILO_ASSERT_IMP(a_data_only_on_read, done_reg && (result_reg.read_record != '0), (op_reg == OP_READ) && (result_reg.status == ST_OK))

endmodule

FILE: design/indexed_ordered_list.sv
// ordered record list, one word per command, busy while a command runs
// a rejected command reports straight from idle, a read waits for the registered memory read;
// insert moves count - position entries, remove count - 1 - position, rotate count - 1 after
// capturing the head: each moved entry costs one memory read and one write
// the next command may be started in the cycle that done is high; results cannot be stalled
// reset clears the entry count and the sequencer at once, entry contents are undefined
module indexed_ordered_list #(
    parameter int DEPTH    = 16,
    parameter int RECORD_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ilo_pkg::cmd_t     cmd,
    output logic              done,
    output ilo_pkg::result_t  result
);
    import ilo_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    mem_ctl_t            mem_ctl;
    logic [IDX_W-1:0]    waddr;
    logic [IDX_W-1:0]    raddr;
    logic [RECORD_W-1:0] wdata;
    logic [RECORD_W-1:0] rdata;

    ilo_ctrl #(
        .DEPTH    (DEPTH),
        .RECORD_W (RECORD_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .mem_ctl (mem_ctl),
        .waddr   (waddr),
        .raddr   (raddr),
        .wdata   (wdata),
        .rdata   (rdata)
    );

    ilo_mem #(
        .DEPTH    (DEPTH),
        .RECORD_W (RECORD_W)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (waddr),
        .raddr (raddr),
        .wdata (wdata),
        .rdata (rdata)
    );

endmodule

FILE: test/indexed_ordered_list_tb.sv
module indexed_ordered_list_tb;
    import ilo_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RECORD_W    = 64;
    localparam int TAIL_CYCLES = 40;
    localparam int LIMIT       = 400000;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    // mirror of the list as the block should hold it
    logic [RECORD_W-1:0] list_mem [DEPTH];
    int                  list_len;
    result_t             pending_results [$];

    int  cycle_cnt   = 0;
    int  err_cnt     = 0;
    int  words_sent  = 0;
    int  words_seen  = 0;
    int  full_hits   = 0;
    int  empty_hits  = 0;
    int  badpos_hits = 0;
    int  few_hits    = 0;
    int  rotate_hits = 0;
    bit  quiet       = 1'b0;

    indexed_ordered_list #(
        .DEPTH    (DEPTH),
        .RECORD_W (RECORD_W)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // applies one command to the mirror and returns what the block should report
    function automatic result_t apply_cmd(input cmd_t c);
        result_t r;
        int      pos;
        logic [RECORD_W-1:0] first;
        r = '0;
        r.status = ST_OK;
        pos = int'(c.position);
        case (c.op)
            OP_INSERT:
            begin
                if (pos > list_len)
                    r.status = ST_BADPOS;
                else if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = c.record[RECORD_W-1:0];
                    list_len++;
                end
            end
            OP_READ:
            begin
                if (pos >= list_len)
                    r.status = ST_BADPOS;
                else
                    r.read_record = 64'(list_mem[pos]);
            end
            OP_REMOVE:
            begin
                if (pos >= list_len)
                    r.status = ST_BADPOS;
                else
                begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            default:
            begin
                if (list_len < 2)
                    r.status = ST_FEW;
                else
                begin
                    first = list_mem[0];
                    for (int i = 0; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_mem[list_len-1] = first;
                    rotate_hits++;
                end
            end
        endcase
        r.entry_count = 5'(list_len);
        case (r.status)
            ST_BADPOS: badpos_hits++;
            ST_FULL:   full_hits++;
            ST_FEW:    few_hits++;
            default:   ;
        endcase
        if (r.status == ST_OK && c.op == OP_REMOVE && list_len == 0)
            empty_hits++;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [63:0] pick_record();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] pick_position(input op_t op);
        if ($urandom_range(0, 99) < 15)
            return 5'($urandom_range(0, 31));
        if (op == OP_INSERT)
            return 5'($urandom_range(0, list_len));
        if (list_len > 0)
            return 5'($urandom_range(0, list_len - 1));
        return 5'($urandom_range(0, 31));
    endfunction

    // holds the word until the block takes it, then predicts its result
    task automatic send_word(input op_t op, input logic [4:0] pos, input logic [63:0] rec);
        cmd_t c;
        int   gap;
        c = '{op: op, position: pos, record: rec};
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_cmd(c));
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            words_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.read_record !== want.read_record)
                begin
                    $display("%0t: read_record exp %h act %h", $time,
                             want.read_record, result.read_record);
                    err_cnt++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status exp %s act %0d", $time,
                             want.status.name(), result.status);
                    err_cnt++;
                end
                if (result.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count exp %0d act %0d", $time,
                             want.entry_count, result.entry_count);
                    err_cnt++;
                end
            end
        end
    end

    task automatic test_empty_list();
        quiet = 1'b1;
        send_word(OP_READ, 5'd0, '1);
        send_word(OP_REMOVE, 5'd0, '0);
        send_word(OP_ROTATE, 5'd0, '0);
        send_word(OP_INSERT, 5'd31, '1);
        send_word(OP_INSERT, 5'd0, 64'h0123_4567_89ab_cdef);
        send_word(OP_ROTATE, 5'd31, '0);
        quiet = 1'b0;
    endtask

    task automatic test_fill_to_full();
        logic [4:0]  pos;
        logic [63:0] rec;
        for (int i = 1; i < DEPTH; i++)
        begin
            case (i % 3)
                0:       pos = 5'd0;
                1:       pos = 5'(list_len);
                default: pos = 5'(list_len / 2);
            endcase
            case (i % 4)
                0:       rec = '0;
                1:       rec = '1;
                2:       rec = {32{2'b10}};
                default: rec = {32{2'b01}};
            endcase
            send_word(OP_INSERT, pos, rec);
        end
        send_word(OP_INSERT, 5'd5, {$urandom, $urandom});
        send_word(OP_INSERT, 5'(DEPTH + 1), {$urandom, $urandom});
        send_word(OP_READ, 5'(DEPTH - 1), '0);
        send_word(OP_READ, 5'(DEPTH), '0);
        send_word(OP_ROTATE, 5'd0, '0);
        send_word(OP_REMOVE, 5'(DEPTH - 1), '0);
    endtask

    // swings the list between empty and full with mostly valid positions
    task automatic test_random_churn();
        int          roll;
        op_t         op;
        int          lean;
        for (int round = 0; round < 9; round++)
        begin
            lean  = round % 3;
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 93; n++)
            begin
                roll = $urandom_range(0, 99);
                if (lean == 0)
                    op = (roll < 60) ? OP_INSERT : (roll < 75) ? OP_READ :
                         (roll < 88) ? OP_REMOVE : OP_ROTATE;
                else if (lean == 1)
                    op = op_t'($urandom_range(0, 3));
                else
                    op = (roll < 15) ? OP_INSERT : (roll < 35) ? OP_READ :
                         (roll < 85) ? OP_REMOVE : OP_ROTATE;
                send_word(op, pick_position(op), pick_record());
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        list_len = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_fill_to_full();
        test_random_churn();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d rotates done", words_sent,
                 words_seen, rotate_hits);
        $display("full %0d, emptied %0d, bad position %0d, too few %0d", full_hits,
                 empty_hits, badpos_hits, few_hits);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
